// File: sv/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent property checked every clock outside reset
`define WPDB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");

// check a condition in the cycle after a trigger
`define WPDB_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("%m failed");

`endif

// File: sv/wpdb_pkg.sv
package wpdb_pkg;

  localparam int MAX_WARPS = 64;
  localparam int MAX_WEFTS = 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int ROW_W     = 64;

  localparam logic [1:0] CFG_NUM_WARPS = 2'd0;
  localparam logic [1:0] CFG_NUM_WEFTS = 2'd1;

  localparam logic [1:0] CELL_DOWN    = 2'd0;
  localparam logic [1:0] CELL_UP      = 2'd1;
  localparam logic [1:0] CELL_NO_YARN = 2'd2;
  localparam logic [1:0] CELL_RSVD    = 2'd3;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_LDWR = 11'b000_0000_0010,
    S_DRC  = 11'b000_0000_0100,
    S_DLC  = 11'b000_0000_1000,
    S_DRD  = 11'b000_0001_0000,
    S_DCMP = 11'b000_0010_0000,
    S_ORD  = 11'b000_0100_0000,
    S_OLAT = 11'b000_1000_0000,
    S_CRD  = 11'b001_0000_0000,
    S_CACC = 11'b010_0000_0000,
    S_OSND = 11'b100_0000_0000
  } state_t;

  function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] v,
                                                input logic [CNT_W-1:0] maxv);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

// File: sv/weave_pattern_draft_builder_unit.sv
// Weave draft builder. Cells are taken row-major, num_wefts rows of num_warps
// cells; each accepted cell is a read-modify-write of the column memory.
// After the last cell the block deduplicates columns: each column is read,
// compared with the stored distinct words in turn and stored as a new one if
// none matches. It then sends max(num_warps, num_wefts) results. Each result
// reads its row and heddle entry and, when it carries a chain word, steps
// through the warps one at a time via the single read port of the heddle map
// memory; a result also waits while the output register is full. No new cell
// is accepted until the last result is loaded into the output register.
// Writes to num_warps or num_wefts restart the load at row 0, column 0.
`include "assert_macros.svh"

module weave_pattern_draft_builder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // cell_req[1:0], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  // position[5:0], heddle_valid[6], heddle_of_warp[12:7], chain_valid[13],
  // chain_row[77:14], heddle_count[84:78], zero pad
  output logic [87:0] out_tdata,
  output logic        out_tlast
);

  localparam int IW = wpdb_pkg::IDX_W;
  localparam int CW = wpdb_pkg::CNT_W;
  localparam int RW = wpdb_pkg::ROW_W;

  wpdb_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] warps_r, wefts_r;
  logic [CW-1:0] warps_eff, wefts_eff, n_eff;
  logic [RW-1:0] wmask;

  logic [CW-1:0] ld_col_r, ld_row_r;
  logic [RW-1:0] row_acc_r;
  logic [IW-1:0] wr_col_r, wr_row_r;
  logic          wr_bit_r, wr_last_r;

  logic [CW-1:0] c_r, d_r, cnt_r, k_r;
  logic [RW-1:0] cur_r, rowbits_r, chain_r;
  logic [IW-1:0] hed_r;

  logic          out_valid_r;
  logic [87:0]   out_data_r;
  logic          out_last_r;

  logic [RW-1:0] row_mem [wpdb_pkg::MAX_WEFTS];
  logic [RW-1:0] col_mem [wpdb_pkg::MAX_WARPS];
  logic [RW-1:0] dist_mem [wpdb_pkg::MAX_WARPS];
  logic [IW-1:0] map_mem [wpdb_pkg::MAX_WARPS];

  logic [RW-1:0] row_rd_r, col_rd_r, dist_rd_r;
  logic [IW-1:0] map_rd_r;

  logic          row_we, col_we, dist_we, map_we;
  logic [IW-1:0] row_waddr, col_waddr, dist_waddr, map_waddr;
  logic [RW-1:0] row_wdata, col_wdata, dist_wdata;
  logic [IW-1:0] map_wdata;
  logic [IW-1:0] row_raddr, col_raddr, dist_raddr, map_raddr;

  logic          in_acc, cell_up, send_ok;
  logic [RW-1:0] row_upd, chain_bit;
  logic [CW-1:0] hed_full;

  assign warps_eff = wpdb_pkg::eff_size(warps_r, CW'(wpdb_pkg::MAX_WARPS));
  assign wefts_eff = wpdb_pkg::eff_size(wefts_r, CW'(wpdb_pkg::MAX_WEFTS));
  assign n_eff     = (warps_eff > wefts_eff) ? warps_eff : wefts_eff;
  assign wmask     = (wefts_eff == CW'(wpdb_pkg::MAX_WEFTS)) ? '1
                   : ((RW'(1) << wefts_eff[IW-1:0]) - RW'(1));

  assign in_tready = (state_r == wpdb_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cell_up   = (in_tdata[1:0] == wpdb_pkg::CELL_UP);
  assign send_ok   = !out_valid_r || out_tready;

  always_comb begin
    row_upd = row_acc_r;
    row_upd[ld_col_r[IW-1:0]] = cell_up;
  end

  assign hed_full  = cnt_r - CW'(1) - CW'(map_rd_r);
  assign chain_bit = RW'(1) << hed_full[IW-1:0];

  // memory port control
  always_comb begin
    row_we     = in_acc && (ld_col_r + CW'(1) >= warps_eff);
    row_waddr  = ld_row_r[IW-1:0];
    row_wdata  = row_upd;
    col_we     = (state_r == wpdb_pkg::S_LDWR);
    col_waddr  = wr_col_r;
    col_wdata  = col_rd_r;
    col_wdata[wr_row_r] = wr_bit_r;
    dist_we    = (state_r == wpdb_pkg::S_DRD) && (d_r == cnt_r);
    dist_waddr = cnt_r[IW-1:0];
    dist_wdata = cur_r;
    map_we     = ((state_r == wpdb_pkg::S_DRD) && (d_r == cnt_r))
              || ((state_r == wpdb_pkg::S_DCMP) && (dist_rd_r == cur_r));
    map_waddr  = c_r[IW-1:0];
    map_wdata  = d_r[IW-1:0];
    row_raddr  = k_r[IW-1:0];
    col_raddr  = (state_r == wpdb_pkg::S_DRC) ? c_r[IW-1:0] : ld_col_r[IW-1:0];
    dist_raddr = d_r[IW-1:0];
    map_raddr  = (state_r == wpdb_pkg::S_CRD) ? c_r[IW-1:0] : k_r[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_waddr] <= row_wdata;
    if (col_we) col_mem[col_waddr] <= col_wdata;
    if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
    if (map_we) map_mem[map_waddr] <= map_wdata;
    row_rd_r  <= row_mem[row_raddr];
    col_rd_r  <= col_mem[col_raddr];
    dist_rd_r <= dist_mem[dist_raddr];
    map_rd_r  <= map_mem[map_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wpdb_pkg::S_IDLE: if (in_acc) state_nxt = wpdb_pkg::S_LDWR;
      wpdb_pkg::S_LDWR: state_nxt = wr_last_r ? wpdb_pkg::S_DRC : wpdb_pkg::S_IDLE;
      wpdb_pkg::S_DRC:  state_nxt = wpdb_pkg::S_DLC;
      wpdb_pkg::S_DLC:  state_nxt = wpdb_pkg::S_DRD;
      wpdb_pkg::S_DRD: begin
        if (d_r != cnt_r) state_nxt = wpdb_pkg::S_DCMP;
        else if (c_r + CW'(1) == warps_eff) state_nxt = wpdb_pkg::S_ORD;
        else state_nxt = wpdb_pkg::S_DRC;
      end
      wpdb_pkg::S_DCMP: begin
        if (dist_rd_r != cur_r) state_nxt = wpdb_pkg::S_DRD;
        else if (c_r + CW'(1) == warps_eff) state_nxt = wpdb_pkg::S_ORD;
        else state_nxt = wpdb_pkg::S_DRC;
      end
      wpdb_pkg::S_ORD:  state_nxt = wpdb_pkg::S_OLAT;
      wpdb_pkg::S_OLAT: state_nxt = (k_r < wefts_eff) ? wpdb_pkg::S_CRD : wpdb_pkg::S_OSND;
      wpdb_pkg::S_CRD:  state_nxt = wpdb_pkg::S_CACC;
      wpdb_pkg::S_CACC: begin
        state_nxt = (c_r + CW'(1) == warps_eff) ? wpdb_pkg::S_OSND : wpdb_pkg::S_CRD;
      end
      wpdb_pkg::S_OSND: begin
        if (send_ok) begin
          state_nxt = (k_r + CW'(1) == n_eff) ? wpdb_pkg::S_IDLE : wpdb_pkg::S_ORD;
        end
      end
      default: state_nxt = wpdb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wpdb_pkg::S_IDLE;
      warps_r     <= CW'(1);
      wefts_r     <= CW'(1);
      ld_col_r    <= '0;
      ld_row_r    <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == wpdb_pkg::S_OSND) && send_ok) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      if (cfg_we && (cfg_index == wpdb_pkg::CFG_NUM_WARPS
                     || cfg_index == wpdb_pkg::CFG_NUM_WEFTS)) begin
        ld_col_r <= '0;
        ld_row_r <= '0;
      end else if (in_acc) begin
        if (ld_col_r + CW'(1) < warps_eff) begin
          ld_col_r <= ld_col_r + CW'(1);
        end else begin
          ld_col_r <= '0;
          ld_row_r <= (ld_row_r + CW'(1) < wefts_eff) ? ld_row_r + CW'(1) : '0;
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          wpdb_pkg::CFG_NUM_WARPS: warps_r <= cfg_data;
          wpdb_pkg::CFG_NUM_WEFTS: wefts_r <= cfg_data;
          default: ;
        endcase
      end

      case (state_r)
        wpdb_pkg::S_LDWR: if (wr_last_r) cnt_r <= '0;
        wpdb_pkg::S_DRD:  if (d_r == cnt_r) cnt_r <= cnt_r + CW'(1);
        wpdb_pkg::S_OSND: begin
          if (send_ok) begin
            out_last_r  <= (k_r + CW'(1) == n_eff);
            out_data_r  <= {3'b000, cnt_r, chain_r, (k_r < wefts_eff), hed_r,
                            (k_r < warps_eff), k_r[IW-1:0]};
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_acc_r <= row_upd;
      wr_col_r  <= ld_col_r[IW-1:0];
      wr_row_r  <= ld_row_r[IW-1:0];
      wr_bit_r  <= cell_up;
      wr_last_r <= (ld_col_r + CW'(1) >= warps_eff) && (ld_row_r + CW'(1) >= wefts_eff);
    end
    case (state_r)
      wpdb_pkg::S_LDWR: c_r <= '0;
      wpdb_pkg::S_DLC: begin
        cur_r <= col_rd_r & wmask;
        d_r   <= '0;
      end
      wpdb_pkg::S_DRD: begin
        if (d_r == cnt_r) begin
          c_r <= c_r + CW'(1);
          k_r <= '0;
        end
      end
      wpdb_pkg::S_DCMP: begin
        if (dist_rd_r == cur_r) begin
          c_r <= c_r + CW'(1);
          k_r <= '0;
        end else begin
          d_r <= d_r + CW'(1);
        end
      end
      wpdb_pkg::S_OLAT: begin
        hed_r     <= (k_r < warps_eff) ? hed_full[IW-1:0] : '0;
        rowbits_r <= row_rd_r;
        chain_r   <= '0;
        c_r       <= '0;
      end
      wpdb_pkg::S_CACC: begin
        if (rowbits_r[c_r[IW-1:0]]) chain_r <= chain_r | chain_bit;
        c_r <= c_r + CW'(1);
      end
      wpdb_pkg::S_OSND: if (send_ok) k_r <= k_r + CW'(1);
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `WPDB_ASSERT(a_cmp_in_range, (state_r == wpdb_pkg::S_DCMP) |-> (d_r < cnt_r))
  `WPDB_ASSERT(a_chain_row_valid, (state_r == wpdb_pkg::S_CACC) |-> (k_r < wefts_eff))
  `WPDB_ASSERT(a_count_bounded,
    (state_r == wpdb_pkg::S_ORD) |-> (cnt_r != '0 && cnt_r <= warps_eff))
  `WPDB_ASSERT_NEXT(a_load_then_write, in_acc, state_r == wpdb_pkg::S_LDWR)

endmodule
